// ===== sv/lca_pkg.sv =====
`default_nettype none
package lca_pkg;
   localparam int NODES = 1024;
   localparam int LEVELS = 10;
   localparam int NW = $clog2(NODES);
   localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int DW = 10;
   localparam int QDEPTH = 2;

   typedef enum logic [1:0] {
      MODE_LOAD  = 2'd0,
      MODE_BUILD = 2'd1,
      MODE_LCA   = 2'd2,
      MODE_DESC  = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type     mode;
      logic [9:0]   x;
      logic [9:0]   y;
      logic [9:0]   par;
      logic         has_par;
      logic [DW-1:0] lvl;
   } item_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_LOAD,
      ST_CLR, ST_CLR_W,
      ST_B_RD0, ST_B_RD1, ST_B_WAIT, ST_B_WR,
      ST_Q_D0, ST_Q_D1, ST_Q_D2,
      ST_P1_RD, ST_P1_WAIT, ST_P1_DEP, ST_P1_DW, ST_P1_DEC,
      ST_CHK,
      ST_P2_RX, ST_P2_WX, ST_P2_RY, ST_P2_WY, ST_P2_DEC,
      ST_F_RX, ST_F_WX, ST_F_RY, ST_F_WY, ST_F_DEC,
      ST_OUT
   } state_type;
endpackage
`default_nettype wire

// ===== sv/lca_front.sv =====
`default_nettype none
module lca_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire lca_pkg::item_type in_item,
   output logic                   q_valid,
   input  wire logic              q_ready,
   output lca_pkg::item_type      q_item
);
   import lca_pkg::*;
   // small fifo that classifies nothing beyond storage; decouples intake
   item_type mem_ff [QDEPTH];
   logic [$clog2(QDEPTH)-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [$clog2(QDEPTH):0]   cnt_ff, cnt_in;
   logic push, pop;

   assign in_ready = (cnt_ff != ($clog2(QDEPTH)+1)'(QDEPTH));
   assign q_valid  = (cnt_ff != '0);
   assign q_item   = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop  = q_valid && q_ready;

   always_comb begin
      wp_in  = push ? wp_ff + 1'b1 : wp_ff;
      rp_in  = pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + {{$clog2(QDEPTH){1'b0}}, push} - {{$clog2(QDEPTH){1'b0}}, pop};
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= in_item;
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
   end
endmodule
`default_nettype wire

// ===== sv/lca_back.sv =====
`default_nettype none
module lca_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_valid,
   output logic                   q_ready,
   input  wire lca_pkg::item_type q_item,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output logic [9:0]             out_node,
   output logic                   out_status,
   output logic                   busy
);
   import lca_pkg::*;
   localparam int AW = LW + NW;
   localparam int EW = NW + 1;

   // jump table: entry = {ok, node}; cleared by a pass after reset
   logic [EW-1:0] jt_mem [LEVELS*NODES];
   logic [DW-1:0] dp_mem [NODES];
   logic [EW-1:0] jt_rd_ff;
   logic [DW-1:0] dp_rd_ff;
   logic [AW-1:0] jt_ra, jt_wa;
   logic [EW-1:0] jt_wd;
   logic          jt_we;
   logic [NW-1:0] dp_ra;

   state_type st_ff, st_in;
   item_type  it_ff, it_in;
   logic [NW-1:0] x_ff, x_in, y_ff, y_in, i_ff, i_in;
   logic [LW-1:0] k_ff, k_in;
   logic [EW-1:0] e_ff, e_in;
   logic [DW-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [AW:0]   clr_ff, clr_in;
   logic [9:0]    on_ff, on_in;
   logic          os_ff, os_in, ov_ff, ov_in;

   function automatic logic [AW-1:0] addr(input logic [LW-1:0] k, input logic [NW-1:0] n);
      return AW'(k) * AW'(NODES) + AW'(n);
   endfunction

   always_ff @(posedge clock) begin
      if (jt_we) jt_mem[jt_wa] <= jt_wd;
      jt_rd_ff <= jt_mem[jt_ra];
      if (st_ff == ST_LOAD && {1'b0, q_item.x} < 11'(NODES))
         dp_mem[q_item.x[NW-1:0]] <= q_item.lvl;
      dp_rd_ff <= dp_mem[dp_ra];
   end

   wire in_rng = ({1'b0, q_item.x} < 11'(NODES)) && ({1'b0, q_item.y} < 11'(NODES));

   always_comb begin
      st_in = st_ff; it_in = it_ff; x_in = x_ff; y_in = y_ff; i_in = i_ff;
      k_in = k_ff; e_in = e_ff; dx_in = dx_ff; dy_in = dy_ff; clr_in = clr_ff;
      on_in = on_ff; os_in = os_ff; ov_in = ov_ff;
      q_ready = 1'b0; jt_ra = addr(k_ff, x_ff); jt_we = 1'b0;
      jt_wa = addr('0, '0); jt_wd = '0; dp_ra = x_ff;
      if (ov_ff && out_ready) ov_in = 1'b0;
      case (st_ff)
         ST_CLR: begin
            jt_we = 1'b1; jt_wa = clr_ff[AW-1:0];
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (AW+1)'(LEVELS*NODES-1)) st_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (q_valid && !ov_ff) begin
               it_in = q_item;
               case (q_item.mode)
                  MODE_LOAD: st_in = ST_LOAD;
                  MODE_BUILD: begin
                     q_ready = 1'b1;
                     if (LEVELS > 1) begin
                        k_in = '0; i_in = '0; st_in = ST_B_RD0;
                     end
                  end
                  default: begin
                     q_ready = 1'b1;
                     if (!in_rng) begin
                        on_in = '0; os_in = 1'b1; ov_in = 1'b1;
                     end else begin
                        x_in = q_item.x[NW-1:0]; y_in = q_item.y[NW-1:0];
                        st_in = ST_Q_D0;
                     end
                  end
               endcase
            end
         end
         ST_LOAD: begin
            q_ready = 1'b1;
            if ({1'b0, q_item.x} < 11'(NODES)) begin
               jt_we = 1'b1; jt_wa = addr('0, q_item.x[NW-1:0]);
               jt_wd = (q_item.has_par && {1'b0, q_item.par} < 11'(NODES)) ?
                       {1'b1, q_item.par[NW-1:0]} : '0;
            end
            st_in = ST_IDLE;
         end
         // build: e = T[k][i]; then T[k][e]; write T[k+1][i]
         ST_B_RD0: begin jt_ra = addr(k_ff, i_ff); st_in = ST_B_RD1; end
         ST_B_RD1: begin
            jt_ra = addr(k_ff, jt_rd_ff[NW-1:0]); e_in = jt_rd_ff; st_in = ST_B_WAIT;
         end
         // hold the read address so T[k][e] stays in the read register
         ST_B_WAIT: begin jt_ra = addr(k_ff, e_ff[NW-1:0]); st_in = ST_B_WR; end
         ST_B_WR: begin
            jt_we = 1'b1; jt_wa = addr(k_ff + 1'b1, i_ff);
            jt_wd = (e_ff[NW] && jt_rd_ff[NW]) ? jt_rd_ff : '0;
            i_in = i_ff + 1'b1; st_in = ST_B_RD0;
            if (i_ff == NW'(NODES-1)) begin
               k_in = k_ff + 1'b1;
               if (k_ff == LW'(LEVELS-2)) st_in = ST_IDLE;
            end
         end
         // depths of x and y
         ST_Q_D0: begin dp_ra = x_ff; st_in = ST_Q_D1; end
         ST_Q_D1: begin dp_ra = y_ff; dx_in = dp_rd_ff; st_in = ST_Q_D2; end
         ST_Q_D2: begin
            dy_in = dp_rd_ff; k_in = LW'(LEVELS-1);
            if (it_ff.mode == MODE_LCA) begin
               if (dx_ff < dp_rd_ff) begin
                  x_in = y_ff; y_in = x_ff; dx_in = dp_rd_ff; dy_in = dx_ff;
               end
               st_in = ST_P1_RD;
            end else if (dx_ff >= dp_rd_ff) begin
               on_in = '0; os_in = 1'b1; ov_in = 1'b1; st_in = ST_IDLE;
            end else begin
               // lift y toward depth(x)+1: keep roles, lifted node in x_ff
               x_in = y_ff; y_in = x_ff; dy_in = dx_ff + 1'b1;
               st_in = ST_P1_RD;
            end
         end
         // pass 1: lift x while depth(T[k][x]) >= dy
         ST_P1_RD: begin jt_ra = addr(k_ff, x_ff); st_in = ST_P1_WAIT; end
         ST_P1_WAIT: begin e_in = jt_rd_ff; st_in = ST_P1_DEP; end
         ST_P1_DEP: begin dp_ra = e_ff[NW-1:0]; st_in = ST_P1_DW; end
         ST_P1_DW: begin dp_ra = e_ff[NW-1:0]; st_in = ST_P1_DEC; end
         ST_P1_DEC: begin
            if (e_ff[NW] && dp_rd_ff >= dy_ff) x_in = e_ff[NW-1:0];
            k_in = k_ff - 1'b1;
            if (k_ff == '0) begin
               if (it_ff.mode == MODE_DESC) begin
                  on_in = 10'(x_in); os_in = 1'b0; ov_in = 1'b1; st_in = ST_IDLE;
               end else st_in = ST_CHK;
            end else st_in = ST_P1_RD;
         end
         ST_CHK: begin
            k_in = LW'(LEVELS-1);
            if (x_ff == y_ff) begin
               on_in = 10'(x_ff); os_in = 1'b0; ov_in = 1'b1; st_in = ST_IDLE;
            end else st_in = ST_P2_RX;
         end
         ST_P2_RX: begin jt_ra = addr(k_ff, x_ff); st_in = ST_P2_WX; end
         ST_P2_WX: begin jt_ra = addr(k_ff, y_ff); st_in = ST_P2_RY; end
         ST_P2_RY: begin e_in = jt_rd_ff; st_in = ST_P2_WY; end
         ST_P2_WY: st_in = ST_P2_DEC;
         ST_P2_DEC: begin
            if (e_ff[NW] && jt_rd_ff[NW] && e_ff[NW-1:0] != jt_rd_ff[NW-1:0]) begin
               x_in = e_ff[NW-1:0]; y_in = jt_rd_ff[NW-1:0];
            end
            k_in = k_ff - 1'b1;
            st_in = (k_ff == '0) ? ST_F_RX : ST_P2_RX;
         end
         ST_F_RX: begin jt_ra = addr('0, x_ff); st_in = ST_F_WX; end
         ST_F_WX: begin jt_ra = addr('0, y_ff); st_in = ST_F_RY; end
         ST_F_RY: begin e_in = jt_rd_ff; st_in = ST_F_WY; end
         ST_F_WY: begin jt_ra = addr('0, x_ff); st_in = ST_F_DEC; end
         ST_F_DEC: begin
            ov_in = 1'b1; st_in = ST_IDLE;
            if (!e_ff[NW] || !jt_rd_ff[NW] || e_ff[NW-1:0] != jt_rd_ff[NW-1:0]) begin
               on_in = '0; os_in = 1'b1;
            end else begin
               on_in = 10'(e_ff[NW-1:0]); os_in = 1'b0;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      it_ff <= it_in; x_ff <= x_in; y_ff <= y_in; i_ff <= i_in; e_ff <= e_in;
      dx_ff <= dx_in; dy_ff <= dy_in; on_ff <= on_in; os_ff <= os_in;
      if (reset) begin
         st_ff <= ST_CLR; clr_ff <= '0; ov_ff <= 1'b0; k_ff <= '0;
      end else begin
         st_ff <= st_in; clr_ff <= clr_in; ov_ff <= ov_in; k_ff <= k_in;
      end
   end

   assign out_valid  = ov_ff;
   assign out_node   = on_ff;
   assign out_status = os_ff;
   assign busy       = (st_ff != ST_IDLE);
endmodule
`default_nettype wire

// ===== sv/lca_binary_lifting.sv =====
`default_nettype none
// Binary-lifting lowest common ancestor engine.
// Request channel (req_valid/req_ready): mode 0 loads a node's parent and
// depth, mode 1 builds the jump table, mode 2 asks the LCA of node and
// other_node, mode 3 asks the child of node on the path down to other_node.
// Response channel (rsp_valid/rsp_ready): one transfer per query (answer_node,
// status); loads and builds return nothing.
// A two-entry queue takes requests while the engine works, so the sender can
// run ahead by two items. The engine handles one item at a time; a build
// makes two jump table reads per entry, and the lifting passes of a query
// read the jump table, which has one read port, at each level, with a depth
// read after each table read in the first pass.
// After reset a clearing pass writes every jump table entry to "none"; the
// engine starts no request during it, though the queue still takes two.
// When the receiver stalls, the finished response holds in its register and
// the engine waits before starting the next item; the queue keeps filling.
module lca_binary_lifting (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_mode,
   input  wire logic [9:0] req_node,
   input  wire logic [9:0] req_other_node,
   input  wire logic [9:0] req_parent,
   input  wire logic       req_has_parent,
   input  wire logic [9:0] req_node_level,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [9:0]      rsp_answer_node,
   output logic            rsp_status
);
   import lca_pkg::*;
   item_type in_item, q_item;
   logic q_valid, q_ready, busy, fr_ready;

   always_comb begin
      in_item.mode    = mode_type'(req_mode);
      in_item.x       = req_node;
      in_item.y       = req_other_node;
      in_item.par     = req_parent;
      in_item.has_par = req_has_parent;
      in_item.lvl     = req_node_level;
   end

   lca_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_valid), .in_ready(fr_ready), .in_item(in_item),
      .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
   );

   lca_back u_back (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
      .out_valid(rsp_valid), .out_ready(rsp_ready),
      .out_node(rsp_answer_node), .out_status(rsp_status), .busy(busy)
   );

   // hold off intake only while the queue is full
   assign req_ready = fr_ready && (busy || !busy);
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
   import lca_pkg::*;

   // Nodes that the forest load covers; random traffic stays inside them.
   localparam int LOADED_NODES = 512;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_mode = MODE_LOAD;
   logic [9:0] req_node = '0;
   logic [9:0] req_other_node = '0;
   logic [9:0] req_parent = '0;
   logic       req_has_parent = 1'b0;
   logic [9:0] req_node_level = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [9:0] rsp_answer_node;
   logic       rsp_status;

   lca_binary_lifting uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_mode(req_mode), .req_node(req_node), .req_other_node(req_other_node),
      .req_parent(req_parent), .req_has_parent(req_has_parent),
      .req_node_level(req_node_level),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_answer_node(rsp_answer_node), .rsp_status(rsp_status)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Mirror of the block: jump table, depths, and which depths were loaded.
   bit         hop_ok [LEVELS][NODES];
   logic [9:0] hop_to [LEVELS][NODES];
   logic [9:0] depth_of [NODES];
   bit         loaded [NODES];

   typedef struct {
      logic [9:0] node;
      logic       status;
   } answer_t;

   answer_t pending_answers[$];
   int      errors = 0;
   bit      no_idle = 1'b0;

   // Directed stimulus; rows with a typed answer bypass the predictor.
   typedef struct {
      mode_type   mode;
      logic [9:0] x, y, par;
      logic       hp;
      logic [9:0] lvl;
      bit         typed;
      logic [9:0] want_node;
      logic       want_status;
   } row_t;

   row_t directed_rows[] = '{
      '{MODE_LOAD,  10'd0,    10'd0, 10'd1023, 1'b0, 10'd0, 0, 10'd0, 1'b0},
      '{MODE_LOAD,  10'd1023, 10'd0, 10'd0,    1'b1, 10'd1, 0, 10'd0, 1'b0},
      '{MODE_LOAD,  10'd5,    10'd0, 10'd0,    1'b1, 10'd1, 0, 10'd0, 1'b0},
      '{MODE_LOAD,  10'd6,    10'd0, 10'd5,    1'b1, 10'd2, 0, 10'd0, 1'b0},
      '{MODE_LOAD,  10'd7,    10'd0, 10'd1023, 1'b0, 10'd0, 0, 10'd0, 1'b0},
      // level 0 only: parent lookups work before any build
      '{MODE_LCA,   10'd1023, 10'd0, 10'd0,    1'b0, 10'd0, 1, 10'd0, 1'b0},
      '{MODE_LCA,   10'd6,    10'd5, 10'd0,    1'b0, 10'd0, 1, 10'd5, 1'b0},
      '{MODE_BUILD, 10'd0,    10'd0, 10'd0,    1'b0, 10'd0, 0, 10'd0, 1'b0},
      '{MODE_LCA,   10'd6,    10'd1023, 10'd0, 1'b0, 10'd0, 1, 10'd0, 1'b0},
      '{MODE_LCA,   10'd0,    10'd0, 10'd0,    1'b0, 10'd0, 1, 10'd0, 1'b0},
      // different trees: no common ancestor
      '{MODE_LCA,   10'd7,    10'd6, 10'd0,    1'b0, 10'd0, 1, 10'd0, 1'b1},
      '{MODE_DESC,  10'd0,    10'd6, 10'd0,    1'b0, 10'd0, 1, 10'd5, 1'b0},
      // x not shallower than y
      '{MODE_DESC,  10'd6,    10'd0, 10'd0,    1'b0, 10'd0, 1, 10'd0, 1'b1},
      '{MODE_DESC,  10'd5,    10'd5, 10'd0,    1'b0, 10'd0, 1, 10'd0, 1'b1},
      // y outside subtree of x
      '{MODE_DESC,  10'd7,    10'd6, 10'd0,    1'b0, 10'd0, 0, 10'd0, 1'b0},
      '{MODE_DESC,  10'd1023, 10'd6, 10'd0,    1'b0, 10'd0, 0, 10'd0, 1'b0}
   };

   function automatic void fill_jump_table();
      logic [9:0] mid;
      for (int k = 0; k + 1 < LEVELS; k++) begin
         for (int i = 0; i < NODES; i++) begin
            if (hop_ok[k][i]) begin
               mid = hop_to[k][i];
               hop_ok[k+1][i] = hop_ok[k][mid];
               hop_to[k+1][i] = hop_ok[k][mid] ? hop_to[k][mid] : 10'd0;
            end else begin
               hop_ok[k+1][i] = 1'b0;
               hop_to[k+1][i] = '0;
            end
         end
      end
   endfunction

   function automatic answer_t common_ancestor(logic [9:0] a, logic [9:0] b);
      answer_t    r;
      logic [9:0] t;
      if (depth_of[a] < depth_of[b]) begin
         t = a; a = b; b = t;
      end
      for (int k = LEVELS - 1; k >= 0; k--)
         if (hop_ok[k][a] && depth_of[hop_to[k][a]] >= depth_of[b]) a = hop_to[k][a];
      if (a == b) begin
         r.node = a; r.status = 1'b0;
         return r;
      end
      for (int k = LEVELS - 1; k >= 0; k--)
         if (hop_ok[k][a] && hop_ok[k][b] && hop_to[k][a] != hop_to[k][b]) begin
            a = hop_to[k][a];
            b = hop_to[k][b];
         end
      if (!hop_ok[0][a] || !hop_ok[0][b] || hop_to[0][a] != hop_to[0][b]) begin
         r.node = '0; r.status = 1'b1;
      end else begin
         r.node = hop_to[0][a]; r.status = 1'b0;
      end
      return r;
   endfunction

   function automatic answer_t child_toward(logic [9:0] a, logic [9:0] b);
      answer_t    r;
      logic [10:0] goal;
      if (depth_of[a] >= depth_of[b]) begin
         r.node = '0; r.status = 1'b1;
         return r;
      end
      goal = depth_of[a] + 11'd1;
      for (int k = LEVELS - 1; k >= 0; k--)
         if (hop_ok[k][b] && depth_of[hop_to[k][b]] >= goal) b = hop_to[k][b];
      r.node = b; r.status = 1'b0;
      return r;
   endfunction

   // Apply one accepted transfer to the mirror and queue its answer.
   function automatic void track_request(mode_type m, logic [9:0] x, logic [9:0] y,
                                         logic [9:0] p, logic hp, logic [9:0] lvl);
      bit ok;
      case (m)
         MODE_LOAD: begin
            if (x < NODES) begin
               ok = hp && (p < NODES);
               hop_ok[0][x] = ok;
               hop_to[0][x] = ok ? p : 10'd0;
               depth_of[x] = lvl;
               loaded[x] = 1'b1;
            end
         end
         MODE_BUILD: fill_jump_table();
         MODE_LCA: pending_answers.push_back(common_ancestor(x, y));
         MODE_DESC: pending_answers.push_back(child_toward(x, y));
      endcase
   endfunction

   function automatic int pick_gap();
      if (no_idle) return 0;
      if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2);
      return $urandom_range(5, 40);
   endfunction

   // Drive one item and hold it until the transfer.
   task automatic send(mode_type m, logic [9:0] x, logic [9:0] y,
                       logic [9:0] p, logic hp, logic [9:0] lvl);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= m;
      req_node <= x;
      req_other_node <= y;
      req_parent <= p;
      req_has_parent <= hp;
      req_node_level <= lvl;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_tracked(mode_type m, logic [9:0] x, logic [9:0] y,
                               logic [9:0] p, logic hp, logic [9:0] lvl);
      send(m, x, y, p, hp, lvl);
      track_request(m, x, y, p, hp, lvl);
   endtask

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // Receiver: random stalls, short mostly, some long, some stretches without.
   int stall_left = 0;
   always @(posedge clock) begin
      answer_t exp_ans;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_answers.size() == 0) begin
            report_mismatch("unexpected transfer, answer_node", rsp_answer_node, -1);
         end else begin
            exp_ans = pending_answers.pop_front();
            if (rsp_answer_node !== exp_ans.node)
               report_mismatch("answer_node", rsp_answer_node, exp_ans.node);
            if (rsp_status !== exp_ans.status)
               report_mismatch("status", rsp_status, exp_ans.status);
         end
      end
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
         stall_left <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3)
                                                   : $urandom_range(10, 60);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Pick a loaded ancestor of y by walking parents a random number of steps.
   function automatic logic [9:0] some_ancestor(logic [9:0] y);
      int steps;
      steps = $urandom_range(1, 12);
      for (int s = 0; s < steps; s++)
         if (hop_ok[0][y] && loaded[hop_to[0][y]]) y = hop_to[0][y];
      return y;
   endfunction

   task automatic random_query();
      logic [9:0] a, b;
      b = 10'($urandom_range(0, LOADED_NODES - 1));
      a = ($urandom_range(0, 3) != 0) ? some_ancestor(b)
                                      : 10'($urandom_range(0, LOADED_NODES - 1));
      if ($urandom_range(0, 1)) send_tracked(MODE_LCA, a, b, 10'($urandom), 1'($urandom), 10'($urandom));
      else send_tracked(MODE_DESC, a, b, 10'($urandom), 1'($urandom), 10'($urandom));
   endtask

   task automatic random_load();
      logic [9:0] n, p;
      n = 10'($urandom_range(1, LOADED_NODES - 1));
      if ($urandom_range(0, 4) != 0) begin
         // well-formed: shallower parent, consistent depth
         p = 10'($urandom_range(0, n - 1));
         send_tracked(MODE_LOAD, n, 10'($urandom), p, 1'b1, depth_of[p] + 10'd1);
      end else begin
         send_tracked(MODE_LOAD, n, 10'($urandom), 10'($urandom_range(0, LOADED_NODES - 1)),
                      1'($urandom), 10'($urandom));
      end
   endtask

   initial begin
      logic [9:0] p;
      int         span;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send(directed_rows[i].mode, directed_rows[i].x, directed_rows[i].y,
              directed_rows[i].par, directed_rows[i].hp, directed_rows[i].lvl);
         if (directed_rows[i].typed) begin
            pending_answers.push_back('{directed_rows[i].want_node,
                                        directed_rows[i].want_status});
         end else begin
            track_request(directed_rows[i].mode, directed_rows[i].x, directed_rows[i].y,
                          directed_rows[i].par, directed_rows[i].hp, directed_rows[i].lvl);
         end
         if (directed_rows[i].typed && directed_rows[i].mode != MODE_LOAD)
            track_request(MODE_LOAD, 10'd0, 10'd0, 10'd0, 1'b0, 10'd0);
      end

      // The line above re-marks node 0 as a root at depth 0, same as loaded.
      // Load a full forest: a few roots, mixed shallow and very deep chains.
      no_idle = 1'b1;
      for (int i = 0; i < LOADED_NODES; i++) begin
         if (i == 0 || $urandom_range(0, 99) == 0) begin
            send_tracked(MODE_LOAD, 10'(i), 10'($urandom), 10'($urandom), 1'b0, 10'd0);
         end else begin
            span = 1 << $urandom_range(0, 9);
            p = (i > span) ? 10'(i - $urandom_range(1, span)) : 10'($urandom_range(0, i - 1));
            send_tracked(MODE_LOAD, 10'(i), 10'($urandom), p, 1'b1, depth_of[p] + 10'd1);
         end
      end
      no_idle = 1'b0;
      send_tracked(MODE_BUILD, 10'($urandom), 10'($urandom), 10'($urandom), 1'($urandom),
                   10'($urandom));

      for (int ph = 0; ph < 4; ph++) begin
         no_idle = (ph == 2);
         repeat (12) random_load();
         // table is stale above level 0 until the build
         repeat (15) random_query();
         send_tracked(MODE_BUILD, 10'($urandom), 10'($urandom), 10'($urandom),
                      1'($urandom), 10'($urandom));
         repeat (110) random_query();
      end
      no_idle = 1'b0;
      req_valid <= 1'b0;

      while (pending_answers.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("status: fail");
      $finish;
   end
endmodule
`default_nettype wire
